// File: design/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Constants, widths and arithmetic helpers of the barometric calibration
// compensation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcc_pkg;

	// Fixed point format of the scaled samples and of the polynomial terms.
	localparam int FRAC_BITS = 24;

	// Field widths.
	localparam int RAW_W  = 24;
	localparam int TEMP_W = 26;
	localparam int PRES_W = 32;
	localparam int CFG_W  = 48;
	localparam int PA_W   = 20;
	localparam int IDX_W  = 3;

	// Output fraction bits: 1/256 degree and 1/64 pascal.
	localparam int TEMP_FRAC = 8;
	localparam int PA_FRAC   = 6;

	// Coefficient widths.
	localparam int C12_W = 12;
	localparam int C20_W = 20;
	localparam int C16_W = 16;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] CFG_CALIB_LOW  = 3'd0;
	localparam logic [IDX_W-1:0] CFG_CALIB_MID  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_CALIB_HIGH = 3'd2;
	localparam logic [IDX_W-1:0] CFG_FLOOR      = 3'd3;
	localparam logic [IDX_W-1:0] CFG_CEILING    = 3'd4;

	localparam logic [PA_W-1:0] FLOOR_RESET   = 20'd30000;
	localparam logic [PA_W-1:0] CEILING_RESET = 20'd120000;

	// The oversampling scale factor 253952 is 31 * 2^13. Rounding the scaled
	// value to nearest reduces to floor((raw * 2^(F-13) + 15) / 31), and with
	// 2^(F-13) = 31*Q + R that is raw*Q + floor((raw*R + 15) / 31).
	localparam int SCALE_POW2  = 13;
	localparam int SCALE_ODD   = 31;
	localparam int SCALE_HALF  = 15;
	localparam int SCALE_SHIFT = FRAC_BITS - SCALE_POW2;
	localparam int SCALE_Q     = (1 << SCALE_SHIFT) / SCALE_ODD;
	localparam int SCALE_R     = (1 << SCALE_SHIFT) % SCALE_ODD;

	// The small remainder term is biased positive, then divided by 31 with a
	// truncated reciprocal that is low by at most one.
	localparam int DIV_W          = 30;
	localparam int DIV_BIAS_SHIFT = 24;
	localparam int DIV_BIAS_Q     = 1 << DIV_BIAS_SHIFT;
	localparam int DIV_OFFSET     = SCALE_ODD * DIV_BIAS_Q + SCALE_HALF;
	localparam int RECIP_31       = (1 << DIV_W) / SCALE_ODD;
	localparam int RECIP_W        = $clog2(RECIP_31 + 1);

	// Datapath widths.
	localparam int PW    = FRAC_BITS + 7;           // scaled P and T
	localparam int QW    = FRAC_BITS + 27;          // inner polynomial terms
	localparam int SW    = (FRAC_BITS + 28) / 2;    // low half of a split operand
	localparam int HW    = QW - SW;                 // high half of a split operand
	localparam int HPW   = PW + HW;
	localparam int LPW   = PW + SW + 1;
	localparam int FULLW = PW + QW;
	localparam int FW    = FRAC_BITS + 32;          // fixed point product result
	localparam int ACC_W = FRAC_BITS + 34;
	localparam int PR_W  = ACC_W - FRAC_BITS + PA_FRAC;
	localparam int TMP_W = PW + 13;

	localparam logic [PRES_W-1:0] PRES_MAX = 32'h7FFF_FFFF;
	localparam logic [PRES_W-1:0] PRES_MIN = 32'h8000_0000;

	typedef logic signed [PW-1:0] scaled_t;
	typedef logic signed [QW-1:0] term_t;
	typedef logic signed [HPW-1:0] hi_prod_t;
	typedef logic signed [LPW-1:0] lo_prod_t;
	typedef logic signed [FW-1:0] fprod_t;

	// Finishes the scaling: corrects the reciprocal quotient and removes the bias.
	function automatic scaled_t scale_finish(input logic [DIV_W-1:0] x,
			input logic [RECIP_W-1:0] q0, input scaled_t base);
		logic [DIV_W-1:0] r;
		logic [RECIP_W-1:0] q;
		r = x - DIV_W'(q0) * DIV_W'(SCALE_ODD);
		q = q0 + RECIP_W'(r >= DIV_W'(SCALE_ODD));
		return base + $signed(PW'(q)) - PW'(DIV_BIAS_Q);
	endfunction

	// Scaled value times the signed upper half of a term.
	function automatic hi_prod_t pp_hi(input scaled_t a, input term_t b);
		logic signed [HW-1:0] bh;
		bh = b[QW-1:SW];
		return HPW'(a) * HPW'(bh);
	endfunction

	// Scaled value times the unsigned lower half of a term.
	function automatic lo_prod_t pp_lo(input scaled_t a, input term_t b);
		logic signed [SW:0] bl;
		bl = {1'b0, b[SW-1:0]};
		return LPW'(a) * LPW'(bl);
	endfunction

	// Joins the two partial products and floors the result by FRAC_BITS.
	function automatic fprod_t fmul_join(input hi_prod_t hp, input lo_prod_t lp);
		logic signed [FULLW-1:0] full;
		logic signed [FULLW-1:0] shifted;
		full = (FULLW'(hp) <<< SW) + FULLW'(lp);
		shifted = full >>> FRAC_BITS;
		return shifted[FW-1:0];
	endfunction

endpackage

// File: design/baro_calibration_compensation.sv
// ----------------------------------------------------------------------------
// baro_calibration_compensation
// Throughput: one request per clock cycle while the output is not stalled; the stage period is set by the
// split 31 x 51 bit fixed point products in stages 6 and 9.
// Reset clears the stage valid bits and returns the configuration registers
// to their defaults (calibration zero, window 30000 to 120000 Pa).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_calibration_compensation
	import bcc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_write,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,

	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [RAW_W-1:0]  pressure_sample,
	input  logic signed [RAW_W-1:0]  temperature_sample,

	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [TEMP_W-1:0] temperature_out,
	output logic signed [PRES_W-1:0] pressure_out,
	output logic                     pressure_saturated,
	output logic                     pressure_plausible
);

	// ------------------------------------------------------------------------
	// Configuration registers. The user must write them only while the pipeline is
	// empty (the block does not enforce this), so the coefficients are taken
	// straight from these registers in every stage that needs them.
	// ------------------------------------------------------------------------
	logic [CFG_W-1:0] calib_low_q;
	logic [CFG_W-1:0] calib_mid_q;
	logic [CFG_W-1:0] calib_high_q;
	logic [PA_W-1:0]  floor_q;
	logic [PA_W-1:0]  ceiling_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_low_q  <= '0;
			calib_mid_q  <= '0;
			calib_high_q <= '0;
			floor_q      <= FLOOR_RESET;
			ceiling_q    <= CEILING_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CALIB_LOW:  calib_low_q  <= cfg_data;
				CFG_CALIB_MID:  calib_mid_q  <= cfg_data;
				CFG_CALIB_HIGH: calib_high_q <= cfg_data;
				CFG_FLOOR:      floor_q      <= cfg_data[PA_W-1:0];
				CFG_CEILING:    ceiling_q    <= cfg_data[PA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Coefficient unpacking. Byte 0 sits in the top byte of the low word, so
	// the packed byte stream maps onto plain bit fields of the three words.
	logic signed [C12_W-1:0] c0;
	logic signed [C12_W-1:0] c1;
	logic signed [C20_W-1:0] c00;
	logic signed [C20_W-1:0] c10;
	logic signed [C16_W-1:0] c01;
	logic signed [C16_W-1:0] c11;
	logic signed [C16_W-1:0] c20;
	logic signed [C16_W-1:0] c21;
	logic signed [C16_W-1:0] c30;

	assign c0  = calib_low_q[47:36];
	assign c1  = calib_low_q[35:24];
	assign c00 = calib_low_q[23:4];
	assign c10 = {calib_low_q[3:0], calib_mid_q[47:32]};
	assign c01 = calib_mid_q[31:16];
	assign c11 = calib_mid_q[15:0];
	assign c20 = calib_high_q[47:32];
	assign c21 = calib_high_q[31:16];
	assign c30 = calib_high_q[15:0];

	// ------------------------------------------------------------------------
	// Flow control. Each stage advances when it is empty or when the stage
	// after it advances, so bubbles are squeezed out and a request can enter
	// while a finished result still waits at the output.
	// ------------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;
	logic adv_s7, adv_s8, adv_s9, adv_s10, adv_s11, adv_s12;

	assign adv_s12 = ~vld_s12 | out_ready;
	assign adv_s11 = ~vld_s11 | adv_s12;
	assign adv_s10 = ~vld_s10 | adv_s11;
	assign adv_s9  = ~vld_s9  | adv_s10;
	assign adv_s8  = ~vld_s8  | adv_s9;
	assign adv_s7  = ~vld_s7  | adv_s8;
	assign adv_s6  = ~vld_s6  | adv_s7;
	assign adv_s5  = ~vld_s5  | adv_s6;
	assign adv_s4  = ~vld_s4  | adv_s5;
	assign adv_s3  = ~vld_s3  | adv_s4;
	assign adv_s2  = ~vld_s2  | adv_s3;
	assign adv_s1  = ~vld_s1  | adv_s2;

	assign in_ready  = adv_s1;
	assign out_valid = vld_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			if (adv_s1)  vld_s1  <= in_valid;
			if (adv_s2)  vld_s2  <= vld_s1;
			if (adv_s3)  vld_s3  <= vld_s2;
			if (adv_s4)  vld_s4  <= vld_s3;
			if (adv_s5)  vld_s5  <= vld_s4;
			if (adv_s6)  vld_s6  <= vld_s5;
			if (adv_s7)  vld_s7  <= vld_s6;
			if (adv_s8)  vld_s8  <= vld_s7;
			if (adv_s9)  vld_s9  <= vld_s8;
			if (adv_s10) vld_s10 <= vld_s9;
			if (adv_s11) vld_s11 <= vld_s10;
			if (adv_s12) vld_s12 <= vld_s11;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: split each raw sample into a multiple of the quotient part of
	// the scale factor and a small biased remainder term for division by 31.
	// ------------------------------------------------------------------------
	logic signed [DIV_W:0] px_full;
	logic signed [DIV_W:0] tx_full;
	logic [DIV_W-1:0]      px_s1, tx_s1;
	scaled_t               pb_s1, tb_s1;

	assign px_full = (DIV_W+1)'(pressure_sample) * (DIV_W+1)'(SCALE_R)
		+ (DIV_W+1)'(DIV_OFFSET);
	assign tx_full = (DIV_W+1)'(temperature_sample) * (DIV_W+1)'(SCALE_R)
		+ (DIV_W+1)'(DIV_OFFSET);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			px_s1 <= px_full[DIV_W-1:0];
			tx_s1 <= tx_full[DIV_W-1:0];
			pb_s1 <= PW'(pressure_sample) * PW'(SCALE_Q);
			tb_s1 <= PW'(temperature_sample) * PW'(SCALE_Q);
		end
	end

	// ------------------------------------------------------------------------
	// Stage 2: reciprocal multiply. The quotient estimate is low by at most one.
	// ------------------------------------------------------------------------
	logic [DIV_W+RECIP_W-1:0] pm, tm;
	logic [RECIP_W-1:0]       pq_s2, tq_s2;
	logic [DIV_W-1:0]         px_s2, tx_s2;
	scaled_t                  pb_s2, tb_s2;

	assign pm = (DIV_W+RECIP_W)'(px_s1) * (DIV_W+RECIP_W)'(RECIP_31);
	assign tm = (DIV_W+RECIP_W)'(tx_s1) * (DIV_W+RECIP_W)'(RECIP_31);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			pq_s2 <= pm[DIV_W+RECIP_W-1:DIV_W];
			tq_s2 <= tm[DIV_W+RECIP_W-1:DIV_W];
			px_s2 <= px_s1;
			tx_s2 <= tx_s1;
			pb_s2 <= pb_s1;
			tb_s2 <= tb_s1;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 3: quotient correction gives the scaled values P and T.
	// ------------------------------------------------------------------------
	scaled_t p_s3, t_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			p_s3 <= scale_finish(px_s2, pq_s2, pb_s2);
			t_s3 <= scale_finish(tx_s2, tq_s2, tb_s2);
		end
	end

	// ------------------------------------------------------------------------
	// Stage 4: all products of a coefficient with P or T. These are exact.
	// ------------------------------------------------------------------------
	logic signed [PW+C16_W-1:0] pc30_s4, pc21_s4, tc01_s4;
	logic signed [PW+C12_W-1:0] tc1_s4;
	scaled_t                    p_s4, t_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			pc30_s4 <= (PW+C16_W)'(p_s3) * (PW+C16_W)'(c30);
			pc21_s4 <= (PW+C16_W)'(p_s3) * (PW+C16_W)'(c21);
			tc01_s4 <= (PW+C16_W)'(t_s3) * (PW+C16_W)'(c01);
			tc1_s4  <= (PW+C12_W)'(t_s3) * (PW+C12_W)'(c1);
			p_s4    <= p_s3;
			t_s4    <= t_s3;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 5: innermost terms of both pressure chains, the constant part of
	// the pressure sum, and the finished temperature with round to nearest.
	// ------------------------------------------------------------------------
	logic signed [TMP_W-1:0]  tsum;
	logic signed [TMP_W-1:0]  tshift;
	term_t                    q1_s5, q3_s5;
	logic signed [ACC_W-1:0]  cacc_s5;
	logic signed [TEMP_W-1:0] temp_s5;
	scaled_t                  p_s5, t_s5;

	assign tsum = (TMP_W'(c0) <<< (FRAC_BITS - 1)) + TMP_W'(tc1_s4)
		+ (TMP_W'(1) <<< (FRAC_BITS - TEMP_FRAC - 1));
	assign tshift = tsum >>> (FRAC_BITS - TEMP_FRAC);

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			q1_s5   <= (QW'(c20) <<< FRAC_BITS) + QW'(pc30_s4);
			q3_s5   <= (QW'(c11) <<< FRAC_BITS) + QW'(pc21_s4);
			cacc_s5 <= (ACC_W'(c00) <<< FRAC_BITS) + ACC_W'(tc01_s4);
			temp_s5 <= tshift[TEMP_W-1:0];
			p_s5    <= p_s4;
			t_s5    <= t_s4;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 6: P * q1 and P * q3, each as two partial products.
	// ------------------------------------------------------------------------
	hi_prod_t                 hp1_s6, hp3_s6;
	lo_prod_t                 lp1_s6, lp3_s6;
	scaled_t                  p_s6, t_s6;
	logic signed [ACC_W-1:0]  cacc_s6;
	logic signed [TEMP_W-1:0] temp_s6;

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			hp1_s6  <= pp_hi(p_s5, q1_s5);
			lp1_s6  <= pp_lo(p_s5, q1_s5);
			hp3_s6  <= pp_hi(p_s5, q3_s5);
			lp3_s6  <= pp_lo(p_s5, q3_s5);
			p_s6    <= p_s5;
			t_s6    <= t_s5;
			cacc_s6 <= cacc_s5;
			temp_s6 <= temp_s5;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 7: join the partial products and floor by the fraction bits.
	// ------------------------------------------------------------------------
	term_t                    f1_s7, f3_s7;
	scaled_t                  p_s7, t_s7;
	logic signed [ACC_W-1:0]  cacc_s7;
	logic signed [TEMP_W-1:0] temp_s7;

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			f1_s7   <= QW'(fmul_join(hp1_s6, lp1_s6));
			f3_s7   <= QW'(fmul_join(hp3_s6, lp3_s6));
			p_s7    <= p_s6;
			t_s7    <= t_s6;
			cacc_s7 <= cacc_s6;
			temp_s7 <= temp_s6;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 8: middle term of the pure pressure chain.
	// ------------------------------------------------------------------------
	term_t                    q2_s8, f3_s8;
	scaled_t                  p_s8, t_s8;
	logic signed [ACC_W-1:0]  cacc_s8;
	logic signed [TEMP_W-1:0] temp_s8;

	always_ff @(posedge clk) begin
		if (adv_s8) begin
			q2_s8   <= (QW'(c10) <<< FRAC_BITS) + f1_s7;
			f3_s8   <= f3_s7;
			p_s8    <= p_s7;
			t_s8    <= t_s7;
			cacc_s8 <= cacc_s7;
			temp_s8 <= temp_s7;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 9: outer products P * q2 and T * (P * q3), as partial products.
	// ------------------------------------------------------------------------
	hi_prod_t                 hp2_s9, hp4_s9;
	lo_prod_t                 lp2_s9, lp4_s9;
	logic signed [ACC_W-1:0]  cacc_s9;
	logic signed [TEMP_W-1:0] temp_s9;

	always_ff @(posedge clk) begin
		if (adv_s9) begin
			hp2_s9  <= pp_hi(p_s8, q2_s8);
			lp2_s9  <= pp_lo(p_s8, q2_s8);
			hp4_s9  <= pp_hi(t_s8, f3_s8);
			lp4_s9  <= pp_lo(t_s8, f3_s8);
			cacc_s9 <= cacc_s8;
			temp_s9 <= temp_s8;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 10: join the outer products.
	// ------------------------------------------------------------------------
	fprod_t                   f2_s10, f4_s10;
	logic signed [ACC_W-1:0]  cacc_s10;
	logic signed [TEMP_W-1:0] temp_s10;

	always_ff @(posedge clk) begin
		if (adv_s10) begin
			f2_s10   <= fmul_join(hp2_s9, lp2_s9);
			f4_s10   <= fmul_join(hp4_s9, lp4_s9);
			cacc_s10 <= cacc_s9;
			temp_s10 <= temp_s9;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 11: full pressure sum, rounded to nearest in units of 1/64 Pa.
	// ------------------------------------------------------------------------
	logic signed [ACC_W-1:0]  psum;
	logic signed [ACC_W-1:0]  pshift;
	logic signed [PR_W-1:0]   pr_s11;
	logic signed [TEMP_W-1:0] temp_s11;

	assign psum = cacc_s10 + ACC_W'(f2_s10) + ACC_W'(f4_s10)
		+ (ACC_W'(1) <<< (FRAC_BITS - PA_FRAC - 1));
	assign pshift = psum >>> (FRAC_BITS - PA_FRAC);

	always_ff @(posedge clk) begin
		if (adv_s11) begin
			pr_s11   <= pshift[PR_W-1:0];
			temp_s11 <= temp_s10;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 12: plausibility window on the unclipped value, then saturation
	// to the signed 32-bit output range. This stage is the output register.
	// A floor above the ceiling simply never matches.
	// ------------------------------------------------------------------------
	logic signed [PR_W-1:0]   lo_lim, hi_lim;
	logic                     fits;
	logic signed [TEMP_W-1:0] temp_s12;
	logic signed [PRES_W-1:0] pres_s12;
	logic                     sat_s12;
	logic                     plaus_s12;

	assign lo_lim = PR_W'({floor_q, {PA_FRAC{1'b0}}});
	assign hi_lim = PR_W'({ceiling_q, {PA_FRAC{1'b0}}});
	assign fits   = (&pr_s11[PR_W-1:PRES_W-1]) | ~(|pr_s11[PR_W-1:PRES_W-1]);

	always_ff @(posedge clk) begin
		if (adv_s12) begin
			temp_s12  <= temp_s11;
			plaus_s12 <= (pr_s11 >= lo_lim) && (pr_s11 <= hi_lim);
			sat_s12   <= ~fits;
			if (fits) begin
				pres_s12 <= pr_s11[PRES_W-1:0];
			end else if (pr_s11[PR_W-1]) begin
				pres_s12 <= PRES_MIN;
			end else begin
				pres_s12 <= PRES_MAX;
			end
		end
	end

	assign temperature_out    = temp_s12;
	assign pressure_out       = pres_s12;
	assign pressure_saturated = sat_s12;
	assign pressure_plausible = plaus_s12;

endmodule
